>>> rtl/scd1_pkg.sv
// Package with the shared types, constants and lookup function of the scan-code decoder.
package scd1_pkg;

   localparam logic [7:0] PrefixByte = 8'hE0;
   localparam logic [7:0] ReleaseBit = 8'h80;
   localparam int unsigned NormalLast = 85;
   localparam int unsigned ExtCount = 12;
   localparam int unsigned ExtIdxWidth = $clog2(ExtCount);

   typedef enum logic [1:0] {
      KIND_PREFIX  = 2'd0,
      KIND_UPDATED = 2'd1,
      KIND_IGNORED = 2'd2
   } event_kind_type;

   typedef struct packed {
      logic                   hit;
      logic [ExtIdxWidth-1:0] idx;
   } ext_lookup_type;

   typedef struct packed {
      event_kind_type         kind;
      logic                   is_extended;
      logic [6:0]             key_code;
      logic                   is_pressed;
      logic [ExtIdxWidth-1:0] ext_idx;
   } decode_type;

   // Maps an extended key code to its place in the extended key store.
   function automatic ext_lookup_type ext_lookup(input logic [6:0] code);
      ext_lookup_type res;
      res.hit = 1'b1;
      res.idx = '0;
      unique case (code)
         7'd29: res.idx = ExtIdxWidth'(0);
         7'd53: res.idx = ExtIdxWidth'(1);
         7'd56: res.idx = ExtIdxWidth'(2);
         7'd71: res.idx = ExtIdxWidth'(3);
         7'd72: res.idx = ExtIdxWidth'(4);
         7'd73: res.idx = ExtIdxWidth'(5);
         7'd75: res.idx = ExtIdxWidth'(6);
         7'd77: res.idx = ExtIdxWidth'(7);
         7'd79: res.idx = ExtIdxWidth'(8);
         7'd80: res.idx = ExtIdxWidth'(9);
         7'd81: res.idx = ExtIdxWidth'(10);
         7'd82: res.idx = ExtIdxWidth'(11);
         default: res.hit = 1'b0;
      endcase
      return res;
   endfunction

endpackage

>>> rtl/scan_code_set1_key_state_decoder.sv
// Top level of the set 1 scan-code decoder with its pressed-key store.
//
// The request channel carries one raw keyboard byte per beat on req_scan_byte.
// The response channel returns one beat per request beat, in order, carrying
// the event kind, the extended flag, the key code and the pressed flag.
// The byte E0 arms the extended prefix; the next other byte is looked up among
// the extended keys and clears the flag again.
// Each request beat is decoded in the cycle it is accepted and its response is
// held in the output register from the next cycle on.
// One beat is accepted every cycle unless the receiver stalls: the decode is a
// small table lookup and a bit write into the key store, done in that cycle.
// If the receiver stalls, the pending response stays in the output register and
// req_ready drops until it is taken; a waiting response never blocks a request
// beat in the same cycle in which it is taken.
// Reset clears the prefix flag, every key bit in the store and the output
// register valid flag; the block accepts a beat in the first cycle after reset.
module scan_code_set1_key_state_decoder (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_scan_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [1:0] rsp_event_kind,
   output logic       rsp_is_extended,
   output logic [6:0] rsp_key_code,
   output logic       rsp_is_pressed
);

   scd1_pkg::decode_type dec;

   logic                               req_fire;
   logic                               prefix_ff;
   logic                               prefix_in;
   logic                               rsp_valid_ff;
   logic                               rsp_valid_in;
   scd1_pkg::event_kind_type           kind_ff;
   logic                               ext_ff;
   logic [6:0]                         code_ff;
   logic                               pressed_ff;
   logic [scd1_pkg::NormalLast:1]      norm_down_ff;
   logic [scd1_pkg::ExtCount-1:0]      ext_down_ff;

   scd1_decode u_decode (
      .scan_byte      (req_scan_byte),
      .prefix_pending (prefix_ff),
      .dec            (dec)
   );

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;

   always_comb begin
      prefix_in = prefix_ff;
      if (req_fire) begin
         prefix_in = (dec.kind == scd1_pkg::KIND_PREFIX);
      end
      rsp_valid_in = rsp_valid_ff;
      if (req_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prefix_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         norm_down_ff <= '0;
         ext_down_ff  <= '0;
      end else begin
         prefix_ff    <= prefix_in;
         rsp_valid_ff <= rsp_valid_in;
         if (req_fire && dec.kind == scd1_pkg::KIND_UPDATED) begin
            if (dec.is_extended) begin
               ext_down_ff[dec.ext_idx] <= dec.is_pressed;
            end else begin
               norm_down_ff[dec.key_code] <= dec.is_pressed;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         kind_ff    <= dec.kind;
         ext_ff     <= dec.is_extended;
         code_ff    <= dec.key_code;
         pressed_ff <= dec.is_pressed;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_event_kind  = 2'(kind_ff);
   assign rsp_is_extended = ext_ff;
   assign rsp_key_code    = code_ff;
   assign rsp_is_pressed  = pressed_ff;

   a_prefix_arms : assert property (@(posedge clock) disable iff (reset)
      req_fire && req_scan_byte == scd1_pkg::PrefixByte |=> prefix_ff)
      else $error("Prefix byte did not arm the prefix flag.");

   a_prefix_fields_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_event_kind == 2'(scd1_pkg::KIND_PREFIX)
      |-> !rsp_is_extended && rsp_key_code == 7'd0 && !rsp_is_pressed)
      else $error("Prefix response carries nonzero key fields.");

   a_normal_store : assert property (@(posedge clock) disable iff (reset)
      req_fire && dec.kind == scd1_pkg::KIND_UPDATED && !dec.is_extended
      |=> norm_down_ff[$past(dec.key_code)] == $past(dec.is_pressed))
      else $error("Normal key bit does not follow the updated key.");

   a_ext_store : assert property (@(posedge clock) disable iff (reset)
      req_fire && dec.kind == scd1_pkg::KIND_UPDATED && dec.is_extended
      |=> ext_down_ff[$past(dec.ext_idx)] == $past(dec.is_pressed))
      else $error("Extended key bit does not follow the updated key.");

   a_ignored_normal : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_event_kind == 2'(scd1_pkg::KIND_IGNORED) && !rsp_is_extended
      |-> rsp_key_code == 7'd0 || rsp_key_code > 7'(scd1_pkg::NormalLast))
      else $error("A mapped normal key was reported as ignored.");

endmodule

>>> rtl/scd1_decode.sv
// Combinational decode of one scan byte against the pending prefix flag.
module scd1_decode (
   input  logic [7:0]          scan_byte,
   input  logic                prefix_pending,
   output scd1_pkg::decode_type dec
);

   logic [6:0]               code;
   logic                     normal_hit;
   scd1_pkg::ext_lookup_type ext;

   assign code       = scan_byte[6:0];
   assign normal_hit = (code != 7'd0) && (code <= 7'(scd1_pkg::NormalLast));
   assign ext        = scd1_pkg::ext_lookup(code);

   always_comb begin
      dec.ext_idx = ext.idx;
      if (scan_byte == scd1_pkg::PrefixByte) begin
         dec.kind        = scd1_pkg::KIND_PREFIX;
         dec.is_extended = 1'b0;
         dec.key_code    = '0;
         dec.is_pressed  = 1'b0;
      end else begin
         dec.is_extended = prefix_pending;
         dec.key_code    = code;
         dec.is_pressed  = ((scan_byte & scd1_pkg::ReleaseBit) == 8'd0);
         if (prefix_pending ? ext.hit : normal_hit) begin
            dec.kind = scd1_pkg::KIND_UPDATED;
         end else begin
            dec.kind = scd1_pkg::KIND_IGNORED;
         end
      end
   end

endmodule
